FILE: sv/afsk_pkg.sv
// Shared types and constants for the AFSK NRZI tone modulator.
// Depends on nothing; used by the top level and the testbench.
`default_nettype none

package afsk_pkg;

   // Request kinds carried in req_tuser.
   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_START = 2'd1,
      CMD_TICK  = 2'd2
   } cmd_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_FRAME_BITS = 2'd0,
      CSR_SAMPLES    = 2'd1,
      CSR_MARK_STEP  = 2'd2,
      CSR_SPACE_STEP = 2'd3
   } csr_index_type;

   // Sequencer states, one-hot.
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   localparam int FRAME_W   = 12;
   localparam int SAMPLE_W  = 10;
   localparam int STEP_W    = 8;
   localparam int PHASE_W   = 8;
   localparam int BYTE_W    = 8;
   localparam int CSR_W     = 12;

   localparam logic [SAMPLE_W-1:0] SAMPLES_RESET    = 10'd39;
   localparam logic [STEP_W-1:0]   MARK_STEP_RESET  = 8'd6;
   localparam logic [STEP_W-1:0]   SPACE_STEP_RESET = 8'd12;

endpackage

`default_nettype wire

FILE: sv/afsk_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`default_nettype none

module afsk_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

FILE: sv/afsk_nrzi_tone_modulator_unit.sv
// Top level of the AFSK NRZI tone modulator: packet store, tone sequencer, ports.
// Depends on afsk_pkg and afsk_ram.
`default_nettype none

// Channel   Direction  Handshake                 Payload
// req_      in         req_tvalid / req_tready   tdata: byte_index, byte_value; tuser: cmd
// rsp_      out        rsp_tvalid / rsp_tready   tdata: tone_level, busy_res; tlast: frame_done
// csr_      in         csr_we (no wait)          csr_index selects the register, csr_wdata
//
// Each request passes through the idle and exec states: in the cycle it is accepted the
// packet store is read at the current byte address (or written, for a byte write); in the
// next cycle the read data is used and the response register is loaded. The store's read
// is registered; no new request is taken until the sequencer is back in idle. Reset is
// synchronous and clears the control state except the request kind; the packet store is
// not cleared. A stalled response holds the sequencer: no request is taken while it waits.

module afsk_nrzi_tone_modulator_unit #(
   parameter int PACKET_BYTES = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [7:0] byte_index, [15:8] byte_value
   input  wire logic [1:0]  req_tuser,   // [1:0] cmd
   // Response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [0] tone_level, [1] busy_res, [7:2] zero
   output logic             rsp_tlast,   // frame_done
   // Configuration port
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [afsk_pkg::CSR_W-1:0] csr_wdata
);

   // Address width of the packet store; at least one bit.
   localparam int ADDR_W = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
   localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(PACKET_BYTES - 1);

   // Configuration registers.
   logic [afsk_pkg::FRAME_W-1:0]  frame_bits_ff;
   logic [afsk_pkg::SAMPLE_W-1:0] samples_ff;
   logic [afsk_pkg::STEP_W-1:0]   mark_step_ff;
   logic [afsk_pkg::STEP_W-1:0]   space_step_ff;

   // Modulator state.
   afsk_pkg::state_type            state_ff, state_in;
   afsk_pkg::cmd_type              cmd_ff, cmd_in;
   logic [afsk_pkg::PHASE_W-1:0]   phase_ff, phase_in;
   logic                           space_ff, space_in;
   logic [afsk_pkg::FRAME_W-1:0]   bitpos_ff, bitpos_in;
   logic [afsk_pkg::SAMPLE_W-1:0]  count_ff, count_in;
   logic [afsk_pkg::BYTE_W-1:0]    shift_ff, shift_in;
   logic                           running_ff, running_in;
   logic                           level_ff, level_in;
   logic [ADDR_W-1:0]              addr_ff, addr_in;

   // Response register.
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_level_ff, rsp_busy_ff, rsp_done_ff;
   logic                           done_in;

   // Packet store interface.
   logic                           req_accept;
   logic                           ram_we;
   logic [afsk_pkg::BYTE_W-1:0]    ram_rd_data;
   logic [7:0]                     req_index;
   logic [7:0]                     req_value;

   // Working values for a tick.
   logic [afsk_pkg::BYTE_W-1:0]    shift_next;
   logic                           space_next;
   logic [afsk_pkg::PHASE_W-1:0]   phase_next;
   logic [afsk_pkg::SAMPLE_W-1:0]  count_inc;
   logic [afsk_pkg::FRAME_W-1:0]   bitpos_inc;

   assign req_index = req_tdata[7:0];
   assign req_value = req_tdata[15:8];

   // A request is taken only while the sequencer is idle and the response slot is
   // empty or being emptied at this edge.
   assign req_tready = (state_ff == afsk_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;

   // Byte writes beyond the store are dropped.
   assign ram_we = req_accept && (afsk_pkg::cmd_type'(req_tuser) == afsk_pkg::CMD_WRITE)
                   && (32'(req_index) < PACKET_BYTES);

   // The store is read every cycle at the current byte address, so the data is ready
   // in the cycle after a request is accepted.
   afsk_ram #(
      .WIDTH  (afsk_pkg::BYTE_W),
      .DEPTH  (PACKET_BYTES),
      .ADDR_W (ADDR_W)
   ) u_packet_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ADDR_W'(req_index)),
      .wr_data (req_value),
      .rd_addr (addr_ff),
      .rd_data (ram_rd_data)
   );

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_bits_ff <= '0;
         samples_ff    <= afsk_pkg::SAMPLES_RESET;
         mark_step_ff  <= afsk_pkg::MARK_STEP_RESET;
         space_step_ff <= afsk_pkg::SPACE_STEP_RESET;
      end else if (csr_we) begin
         unique case (afsk_pkg::csr_index_type'(csr_index))
            afsk_pkg::CSR_FRAME_BITS: frame_bits_ff <= csr_wdata[afsk_pkg::FRAME_W-1:0];
            afsk_pkg::CSR_SAMPLES:    samples_ff    <= csr_wdata[afsk_pkg::SAMPLE_W-1:0];
            afsk_pkg::CSR_MARK_STEP:  mark_step_ff  <= csr_wdata[afsk_pkg::STEP_W-1:0];
            afsk_pkg::CSR_SPACE_STEP: space_step_ff <= csr_wdata[afsk_pkg::STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // Tick datapath. At the first sample of a bit the next packet bit is brought to
   // the bottom of the shift byte: a fresh byte from the store on a byte boundary,
   // otherwise the previous byte shifted down. A zero bit flips the tone (NRZI).
   always_comb begin
      shift_next = shift_ff;
      space_next = space_ff;
      if (count_ff == '0) begin
         if (bitpos_ff[2:0] == 3'd0) begin
            shift_next = ram_rd_data;
         end else begin
            shift_next = shift_ff >> 1;
         end
         if (!shift_next[0]) begin
            space_next = !space_ff;
         end
      end
      phase_next = phase_ff + (space_next ? space_step_ff : mark_step_ff);
      count_inc  = count_ff + 1'b1;
      bitpos_inc = bitpos_ff + 1'b1;
   end

   // Sequencer: take a request, then act on it once the store data has arrived.
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      phase_in     = phase_ff;
      space_in     = space_ff;
      bitpos_in    = bitpos_ff;
      count_in     = count_ff;
      shift_in     = shift_ff;
      running_in   = running_ff;
      level_in     = level_ff;
      addr_in      = addr_ff;
      done_in      = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         afsk_pkg::ST_IDLE: begin
            if (req_accept) begin
               cmd_in   = afsk_pkg::cmd_type'(req_tuser);
               state_in = afsk_pkg::ST_EXEC;
            end
         end
         afsk_pkg::ST_EXEC: begin
            case (cmd_ff)
               afsk_pkg::CMD_START: begin
                  phase_in   = '0;
                  bitpos_in  = '0;
                  count_in   = '0;
                  space_in   = 1'b0;
                  running_in = 1'b1;
                  addr_in    = '0;
               end
               afsk_pkg::CMD_TICK: begin
                  if (running_ff) begin
                     if (bitpos_ff == frame_bits_ff) begin
                        // Frame end: stop without moving the phase.
                        running_in = 1'b0;
                        done_in    = 1'b1;
                     end else begin
                        shift_in = shift_next;
                        space_in = space_next;
                        phase_in = phase_next;
                        level_in = phase_next[afsk_pkg::PHASE_W-1];
                        count_in = count_inc;
                        if (count_inc == samples_ff) begin
                           count_in  = '0;
                           bitpos_in = bitpos_inc;
                           // Byte address follows bit_position / 8 modulo the store
                           // depth; a wrap of the bit counter restarts it at zero.
                           if (bitpos_inc == '0) begin
                              addr_in = '0;
                           end else if (bitpos_inc[2:0] == 3'd0) begin
                              addr_in = (addr_ff == ADDR_LAST) ? '0 : addr_ff + 1'b1;
                           end
                        end
                     end
                  end
               end
               default: ;
            endcase
            rsp_valid_in = 1'b1;
            state_in     = afsk_pkg::ST_IDLE;
         end
         default: state_in = afsk_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= afsk_pkg::ST_IDLE;
         phase_ff     <= '0;
         space_ff     <= 1'b0;
         bitpos_ff    <= '0;
         count_ff     <= '0;
         shift_ff     <= '0;
         running_ff   <= 1'b0;
         level_ff     <= 1'b0;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         space_ff     <= space_in;
         bitpos_ff    <= bitpos_in;
         count_ff     <= count_in;
         shift_ff     <= shift_in;
         running_ff   <= running_in;
         level_ff     <= level_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request kind and response payload need no reset.
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      if (state_ff == afsk_pkg::ST_EXEC) begin
         rsp_level_ff <= level_in;
         rsp_busy_ff  <= running_in;
         rsp_done_ff  <= done_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_busy_ff, rsp_level_ff};
   assign rsp_tlast  = rsp_done_ff;

endmodule

`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench for afsk_nrzi_tone_modulator_unit: drives byte writes, frame starts
// and sample ticks, predicts each response in-line and compares every response field.
// Depends on afsk_pkg and the modulator RTL only.
`timescale 1ns / 1ps

module testbench;

   // The request kind that the block leaves undefined; it must change nothing.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam int IDLE_PERCENT  = 27;
   localparam int RESET_CYCLES  = 5;
   // Idle time after the last response, so that the block is settled before a register write.
   localparam int SETTLE_CYCLES = 4;
   // Cycles without any handshake before the run is declared hung.
   localparam int QUIET_LIMIT   = 2000;
   localparam int REPORT_LINES  = 50;
   localparam int CSR_BITS      = afsk_pkg::CSR_W;

   typedef struct packed {
      logic tone_level;
      logic busy_res;
      logic frame_done;
   } tone_out_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // [7:0] byte_index, [15:8] byte_value
   logic [1:0]  req_tuser  = '0;   // [1:0] cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // [0] tone_level, [1] busy_res, [7:2] zero
   logic        rsp_tlast;         // frame_done
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_index  = '0;
   logic [CSR_BITS-1:0] csr_wdata = '0;

   afsk_nrzi_tone_modulator_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // Shadow copy of the modulator. Every field starts at its reset value; the packet store
   // starts unknown, and the stimulus makes sure that no unwritten byte is ever fetched.
   // ---------------------------------------------------------------------------------------
   logic [7:0]                    packet_copy [0:255];
   logic [afsk_pkg::PHASE_W-1:0]  phase_acc      = '0;
   logic                          space_tone     = 1'b0;
   logic [afsk_pkg::FRAME_W-1:0]  bit_pos        = '0;
   logic [afsk_pkg::SAMPLE_W-1:0] sample_cnt     = '0;
   logic [afsk_pkg::BYTE_W-1:0]   shift_reg      = '0;
   logic                          frame_running  = 1'b0;
   logic                          level_now      = 1'b0;

   logic [afsk_pkg::FRAME_W-1:0]  cfg_frame_bits = '0;
   logic [afsk_pkg::SAMPLE_W-1:0] cfg_samples    = afsk_pkg::SAMPLES_RESET;
   logic [afsk_pkg::STEP_W-1:0]   cfg_mark       = afsk_pkg::MARK_STEP_RESET;
   logic [afsk_pkg::STEP_W-1:0]   cfg_space      = afsk_pkg::SPACE_STEP_RESET;

   // Responses owed by the block, oldest first.
   tone_out_type tone_outputs_due [$];

   int  requests_sent  = 0;
   int  responses_seen = 0;
   int  mismatch_count = 0;
   int  quiet_cycles   = 0;
   // While set, neither side inserts idle cycles.
   bit  steady         = 1'b0;

   // Applies one accepted request to the shadow state and queues the response it owes.
   function automatic void advance_tone_state(input logic [1:0] kind, input logic [7:0] index,
                                              input logic [7:0] value);
      tone_out_type due;
      due.frame_done = 1'b0;
      case (kind)
         afsk_pkg::CMD_WRITE: begin
            packet_copy[index] = value;
         end
         afsk_pkg::CMD_START: begin
            phase_acc     = '0;
            bit_pos       = '0;
            sample_cnt    = '0;
            space_tone    = 1'b0;
            frame_running = 1'b1;
         end
         afsk_pkg::CMD_TICK: begin
            if (frame_running && bit_pos == cfg_frame_bits) begin
               // The frame ends on this tick; the phase does not move.
               frame_running  = 1'b0;
               due.frame_done = 1'b1;
            end else if (frame_running) begin
               if (sample_cnt == '0) begin
                  // A fresh byte at each byte boundary, otherwise the next bit up.
                  if (bit_pos[2:0] == 3'd0) begin
                     shift_reg = packet_copy[bit_pos[10:3]];
                  end else begin
                     shift_reg = shift_reg >> 1;
                  end
                  // NRZI: a zero bit swaps the tone, a one bit keeps it.
                  if (!shift_reg[0]) begin
                     space_tone = !space_tone;
                  end
               end
               phase_acc  = phase_acc + (space_tone ? cfg_space : cfg_mark);
               level_now  = phase_acc[afsk_pkg::PHASE_W-1];
               // The counter is ten bits wide, so a zero setting gives 1024 ticks per bit.
               sample_cnt = sample_cnt + 1'b1;
               if (sample_cnt == cfg_samples) begin
                  sample_cnt = '0;
                  bit_pos    = bit_pos + 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      due.tone_level = level_now;
      due.busy_res   = frame_running;
      tone_outputs_due.push_back(due);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      if (mismatch_count <= REPORT_LINES) begin
         $display("MISMATCH %s: got %0d, expected %0d (response %0d)", what, got, want,
                  responses_seen);
      end
   endtask

   task automatic check_response();
      tone_out_type want;
      responses_seen++;
      if (tone_outputs_due.size() == 0) begin
         report_mismatch("response with no request outstanding", int'(rsp_tdata), 0);
      end else begin
         want = tone_outputs_due.pop_front();
         if (rsp_tdata[0] !== want.tone_level) begin
            report_mismatch("tone_level", int'(rsp_tdata[0]), int'(want.tone_level));
         end
         if (rsp_tdata[1] !== want.busy_res) begin
            report_mismatch("busy_res", int'(rsp_tdata[1]), int'(want.busy_res));
         end
         if (rsp_tlast !== want.frame_done) begin
            report_mismatch("frame_done", int'(rsp_tlast), int'(want.frame_done));
         end
         if (rsp_tdata[7:2] !== 6'd0) begin
            report_mismatch("tdata padding", int'(rsp_tdata[7:2]), 0);
         end
      end
   endtask

   // Response side: check at each accepting edge and choose whether to stall next cycle.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_response();
         end
         rsp_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Watchdog: a block that stops moving requests and responses ends the run.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Sends one request. It is entered and left just after a rising edge; tvalid stays high
   // on return so that back-to-back requests need no second assignment in one step.
   task automatic send_request(input logic [1:0] kind, input logic [7:0] index,
                               input logic [7:0] value);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {value, index};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      advance_tone_state(kind, index, value);
      requests_sent++;
   endtask

   // Tick requests carry random, ignored data so that tdata toggles throughout.
   task automatic send_tick();
      send_request(afsk_pkg::CMD_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)));
   endtask

   task automatic tick_until_idle(input int cap);
      int n = 0;
      while (frame_running && n < cap) begin
         send_tick();
         n++;
      end
   endtask

   // Holds the request side back until every owed response has arrived, then lets the
   // block settle so that registers can be written safely.
   task automatic await_drain();
      req_tvalid <= 1'b0;
      while (tone_outputs_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write; only called with the block drained, so the shadow copy may take the
   // new value at once.
   task automatic write_csr(input afsk_pkg::csr_index_type index,
                            input logic [CSR_BITS-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         afsk_pkg::CSR_FRAME_BITS: cfg_frame_bits = value[afsk_pkg::FRAME_W-1:0];
         afsk_pkg::CSR_SAMPLES:    cfg_samples    = value[afsk_pkg::SAMPLE_W-1:0];
         afsk_pkg::CSR_MARK_STEP:  cfg_mark       = value[afsk_pkg::STEP_W-1:0];
         afsk_pkg::CSR_SPACE_STEP: cfg_space      = value[afsk_pkg::STEP_W-1:0];
         default: begin
         end
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Short hand-made sequence: idle ticks, the unused kind, store writes at both address
   // extremes, the empty frame that ends on its first tick, and a full two-byte frame with
   // the phase steps at their extremes.
   task automatic test_directed_cases();
      send_tick();
      send_request(CMD_UNUSED, 8'hFF, 8'hFF);
      send_request(afsk_pkg::CMD_WRITE, 8'h00, 8'hFF);
      send_request(afsk_pkg::CMD_WRITE, 8'hFF, 8'h00);
      send_request(afsk_pkg::CMD_WRITE, 8'h01, 8'h5A);
      send_request(afsk_pkg::CMD_START, 8'h00, 8'h00);
      send_tick();
      send_tick();
      await_drain();
      write_csr(afsk_pkg::CSR_FRAME_BITS, 12'd16);
      write_csr(afsk_pkg::CSR_SAMPLES, 12'd1);
      write_csr(afsk_pkg::CSR_MARK_STEP, 12'd255);
      write_csr(afsk_pkg::CSR_SPACE_STEP, 12'd0);
      send_request(afsk_pkg::CMD_START, 8'hFF, 8'hFF);
      tick_until_idle(20);
      send_tick();
   endtask

   // Fills the whole packet store with random bytes, so that any later frame fetches only
   // written bytes.
   task automatic test_store_load();
      for (int addr = 0; addr < 256; addr++) begin
         send_request(afsk_pkg::CMD_WRITE, addr[7:0], 8'($urandom_range(255)));
      end
   endtask

   // Random frames: mostly short frames with random steps, driven by ticks, with restarts,
   // store writes and the unused kind mixed in as noise.
   task automatic test_random_frames(input int count, input bit calm);
      int first;
      int spent;
      int after_end;
      int roll;
      steady = calm;
      first  = requests_sent;
      while (requests_sent - first < count) begin
         await_drain();
         write_csr(afsk_pkg::CSR_FRAME_BITS,
                   CSR_BITS'(($urandom_range(7) == 0) ? $urandom_range(25, 300)
                                                      : $urandom_range(0, 24)));
         write_csr(afsk_pkg::CSR_SAMPLES,
                   CSR_BITS'(($urandom_range(7) == 0) ? $urandom_range(5, 40)
                                                      : $urandom_range(1, 4)));
         write_csr(afsk_pkg::CSR_MARK_STEP, CSR_BITS'($urandom_range(255)));
         write_csr(afsk_pkg::CSR_SPACE_STEP, CSR_BITS'($urandom_range(255)));
         send_request(afsk_pkg::CMD_START, 8'($urandom_range(255)), 8'($urandom_range(255)));
         spent     = 0;
         after_end = 0;
         while (spent < 90 && after_end < 2) begin
            roll = $urandom_range(99);
            if (roll < 83) begin
               send_tick();
            end else if (roll < 88) begin
               send_request(afsk_pkg::CMD_START, 8'($urandom_range(255)),
                            8'($urandom_range(255)));
            end else if (roll < 94) begin
               send_request(afsk_pkg::CMD_WRITE, 8'($urandom_range(255)),
                            8'($urandom_range(255)));
            end else begin
               send_request(CMD_UNUSED, 8'($urandom_range(255)), 8'($urandom_range(255)));
            end
            spent++;
            if (!frame_running) begin
               after_end++;
            end
         end
      end
      steady = 1'b0;
   endtask

   // Counter corner cases: the zero sample setting, which must not close a bit when the
   // count passes zero, followed by a setting raised to just above the running count, and
   // a frame length lowered during a frame to the bit position already reached.
   task automatic test_counter_extremes();
      await_drain();
      write_csr(afsk_pkg::CSR_FRAME_BITS, 12'd1);
      write_csr(afsk_pkg::CSR_SAMPLES, 12'd0);
      write_csr(afsk_pkg::CSR_MARK_STEP, 12'd37);
      write_csr(afsk_pkg::CSR_SPACE_STEP, 12'd91);
      send_request(afsk_pkg::CMD_START, 8'h00, 8'h00);
      repeat (12) send_tick();
      // The sample count stands at twelve; the next tick closes the first bit.
      await_drain();
      write_csr(afsk_pkg::CSR_SAMPLES, 12'd13);
      tick_until_idle(20);

      // Twenty bits into a frame of 2048, the length drops to twenty.
      await_drain();
      write_csr(afsk_pkg::CSR_FRAME_BITS, 12'd2048);
      write_csr(afsk_pkg::CSR_SAMPLES, 12'd1);
      send_request(afsk_pkg::CMD_START, 8'h00, 8'h00);
      repeat (20) send_tick();
      await_drain();
      write_csr(afsk_pkg::CSR_FRAME_BITS, 12'd20);
      tick_until_idle(20);
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_store_load();
      test_random_frames(200, 1'b0);
      test_counter_extremes();
      // A long stretch with neither side idling.
      test_random_frames(130, 1'b1);
      await_drain();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && tone_outputs_due.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/afsk_pkg.sv
sv/afsk_ram.sv
sv/afsk_nrzi_tone_modulator_unit.sv
test/testbench.sv
